// ----- rtl/core/lscr_pkg.sv -----
// Shared types and constants for the LIFO stack with checksum and run count.
// Holds the operation and status codes, the controller states and the
// command and status groups between controller and datapath. No dependencies.
`default_nettype none

package lscr_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RELOAD,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic reload;
  } lscr_cmd_t;

  typedef struct packed {
    logic need_reload;
  } lscr_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/lscr_ctrl.sv -----
// Controller state machine for the LIFO stack unit.
// Depends on lscr_pkg for the state type and the command and status groups.
`default_nettype none

module lscr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire lscr_pkg::lscr_stat_t stat,
  output lscr_pkg::lscr_cmd_t     cmd,
  output logic                    busy,
  output logic                    done
);

  lscr_pkg::state_t state;
  lscr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lscr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lscr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lscr_pkg::ST_EXEC;
        end
      end
      lscr_pkg::ST_EXEC: begin
        if (stat.need_reload) begin
          state_next = lscr_pkg::ST_RELOAD;
        end else begin
          state_next = lscr_pkg::ST_REPORT;
        end
      end
      lscr_pkg::ST_RELOAD: state_next = lscr_pkg::ST_REPORT;
      lscr_pkg::ST_REPORT: state_next = lscr_pkg::ST_IDLE;
      default:             state_next = lscr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      lscr_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      lscr_pkg::ST_EXEC:   cmd.exec = 1'b1;
      lscr_pkg::ST_RELOAD: cmd.reload = 1'b1;
      lscr_pkg::ST_REPORT: done = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/lscr_dpath.sv -----
// Datapath of the LIFO stack unit: entry memory, top-of-stack registers,
// fill level, running sum and result registers. Depends on lscr_pkg.
`default_nettype none

module lscr_dpath #(
  parameter int DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lscr_pkg::lscr_cmd_t  cmd,
  input  wire logic [1:0]           func,
  input  wire logic signed [31:0]   push_value,
  output lscr_pkg::lscr_stat_t      stat,
  output logic signed [31:0]        read_value,
  output logic [1:0]                status,
  output logic [6:0]                element_count,
  output logic signed [31:0]        value_sum,
  output logic [5:0]                run_total
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = 32 + CW + 1;

  logic [MW-1:0]      mem [DEPTH];
  logic [MW-1:0]      rd_word;
  logic [AW-1:0]      rd_addr;

  logic [1:0]         op_func;
  logic signed [31:0] op_value;
  logic [CW-1:0]      fill;
  logic [31:0]        sum;
  logic signed [31:0] top_value;
  logic [CW-1:0]      top_runs;
  logic               top_dir;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  logic               is_empty;
  logic               is_full;
  logic               push_ok;
  logic               new_dir;
  logic [CW-1:0]      new_runs;
  logic [CW-1:0]      fill_less2;

  assign is_empty = (fill == '0);
  assign is_full  = (fill >= CW'(DEPTH));
  assign push_ok  = (lscr_pkg::func_t'(op_func) == lscr_pkg::FUNC_PUSH) && !is_full;

  always_comb begin
    new_dir  = 1'b0;
    new_runs = CW'(1);
    if (!is_empty) begin
      new_dir = (op_value <= top_value);
      if (fill >= CW'(2)) begin
        new_runs = top_runs + CW'(new_dir != top_dir);
      end
    end
  end

  assign fill_less2 = fill - CW'(2);
  assign rd_addr    = fill_less2[AW-1:0];

  assign stat.need_reload = (lscr_pkg::func_t'(op_func) == lscr_pkg::FUNC_POP)
                            && (fill >= CW'(2));

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[fill[AW-1:0]] <= {op_value, new_runs, new_dir};
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_func  <= func;
      op_value <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      sum        <= '0;
      res_value  <= '0;
      res_status <= lscr_pkg::STATUS_OK;
    end else if (cmd.exec) begin
      res_value  <= '0;
      res_status <= lscr_pkg::STATUS_OK;
      unique case (lscr_pkg::func_t'(op_func)) inside
        lscr_pkg::FUNC_PUSH: begin
          if (is_full) begin
            res_status <= lscr_pkg::STATUS_FULL;
          end else begin
            fill <= fill + CW'(1);
            sum  <= sum + op_value;
          end
        end
        lscr_pkg::FUNC_POP, lscr_pkg::FUNC_PEEK: begin
          if (is_empty) begin
            res_status <= lscr_pkg::STATUS_EMPTY;
          end else begin
            res_value <= top_value;
            if (lscr_pkg::func_t'(op_func) == lscr_pkg::FUNC_POP) begin
              fill <= fill - CW'(1);
              sum  <= sum - top_value;
            end
          end
        end
        lscr_pkg::FUNC_CLEAR: begin
          fill <= '0;
          sum  <= '0;
        end
        default: res_status <= lscr_pkg::STATUS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      top_value <= op_value;
      top_runs  <= new_runs;
      top_dir   <= new_dir;
    end else if (cmd.reload) begin
      top_value <= rd_word[MW-1 -: 32];
      top_runs  <= rd_word[CW:1];
      top_dir   <= rd_word[0];
    end
  end

  assign read_value    = res_value;
  assign status        = res_status;
  assign element_count = 7'(fill);
  assign value_sum     = sum;
  assign run_total     = is_empty ? 6'd0 : 6'(top_runs);

endmodule

`default_nettype wire

// ----- rtl/core/lifo_stack_with_checksum_and_runs_unit.sv -----
// Top level of the LIFO stack unit with running checksum and run count.
// An item accepted in the idle state is executed and then reported with done;
// a pop that leaves entries passes through the reload state before the report, as the new
// top entry is fetched through the memory's registered read port.
// No new item is taken until the last is reported; busy is high meanwhile.
// Reset empties the stack and clears the sum; stored entries are not cleared.
`default_nettype none

module lifo_stack_with_checksum_and_runs_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] push_value,
  output logic                    done,
  output logic signed [31:0]      read_value,
  output logic [1:0]              status,
  output logic [6:0]              element_count,
  output logic signed [31:0]      value_sum,
  output logic [5:0]              run_total
);

  lscr_pkg::lscr_cmd_t  cmd;
  lscr_pkg::lscr_stat_t stat;

  lscr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lscr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .push_value    (push_value),
    .stat          (stat),
    .read_value    (read_value),
    .status        (status),
    .element_count (element_count),
    .value_sum     (value_sum),
    .run_total     (run_total)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the LIFO stack unit with running checksum and run count.
// It predicts every result from the accepted items and checks them field by field.
// Depends on lscr_pkg and lifo_stack_with_checksum_and_runs_unit.
`timescale 1ns / 100ps

module testbench;
  import lscr_pkg::*;

  localparam int STACK_DEPTH = 64;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         element_count;
    logic signed [31:0] value_sum;
    logic [5:0]         run_total;
  } stack_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = FUNC_PUSH;
  logic signed [31:0] push_value = '0;
  logic               done;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         element_count;
  logic signed [31:0] value_sum;
  logic [5:0]         run_total;

  logic signed [31:0] stored_values [STACK_DEPTH];
  logic [5:0]         stored_runs [STACK_DEPTH];
  logic               stored_rising [STACK_DEPTH];
  int unsigned        fill_level = 0;
  logic signed [31:0] checksum = '0;

  stack_result_t pending_results[$];
  int            failures = 0;
  bit            back_to_back = 1'b0;

  lifo_stack_with_checksum_and_runs_unit #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .push_value(push_value),
    .done(done),
    .read_value(read_value),
    .status(status),
    .element_count(element_count),
    .value_sum(value_sum),
    .run_total(run_total)
  );

  always #2 clk = ~clk;

  function automatic void predict_stack_result(input func_t op,
                                               input logic signed [31:0] value);
    stack_result_t r;
    int unsigned   i;
    logic [5:0]    runs;
    logic          rising;
    r = '0;
    case (op) inside
      FUNC_PUSH: begin
        if (fill_level >= STACK_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          i = fill_level;
          runs = 6'd1;
          rising = 1'b0;
          if (i >= 1) begin
            rising = (value <= stored_values[i - 1]);
            if (i >= 2)
              runs = stored_runs[i - 1] + (rising != stored_rising[i - 1]);
          end
          stored_values[i] = value;
          stored_runs[i] = runs;
          stored_rising[i] = rising;
          fill_level = i + 1;
          checksum = checksum + value;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (fill_level == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.read_value = stored_values[fill_level - 1];
          if (op == FUNC_POP) begin
            fill_level = fill_level - 1;
            checksum = checksum - r.read_value;
          end
        end
      end
      default: begin
        fill_level = 0;
        checksum = '0;
      end
    endcase
    r.element_count = fill_level[6:0];
    r.value_sum = checksum;
    r.run_total = (fill_level == 0) ? 6'd0 : stored_runs[fill_level - 1];
    pending_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh7ffffffe;
          3: return 32'sh80000001;
          4: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input func_t op, input logic signed [31:0] value);
    int gap;
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    func <= op;
    push_value <= value;
    do @(posedge clk); while (busy);
    predict_stack_result(op, value);
  endtask

  task automatic report_field(input string field, input logic signed [31:0] got,
                              input logic signed [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result reported with no item outstanding", $time);
        failures++;
      end else begin
        want = pending_results.pop_front();
        report_field("read_value", read_value, want.read_value);
        report_field("status", status, want.status);
        report_field("element_count", element_count, want.element_count);
        report_field("value_sum", value_sum, want.value_sum);
        report_field("run_total", run_total, want.run_total);
      end
    end
  end

  task automatic test_directed();
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_PEEK, 32'sd0);
    send_item(FUNC_CLEAR, 32'sd0);
    send_item(FUNC_PUSH, 32'sh7fffffff);
    send_item(FUNC_PUSH, 32'sh80000000);
    send_item(FUNC_PEEK, 32'sd0);
    send_item(FUNC_PUSH, 32'sd0);
    send_item(FUNC_PUSH, -32'sd1);
    send_item(FUNC_PUSH, -32'sd1);
    send_item(FUNC_PUSH, 32'sd1);
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_PEEK, 32'sd0);
    send_item(FUNC_PUSH, 32'sh7fffffff);
    send_item(FUNC_PUSH, 32'sh7fffffff);
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_CLEAR, 32'sd0);
    send_item(FUNC_PEEK, 32'sd0);
    send_item(FUNC_PUSH, 32'sh80000000);
    send_item(FUNC_PUSH, 32'sh80000000);
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_POP, 32'sd0);
  endtask

  // With zigzag set the values alternate low and high, which gives the largest run count.
  task automatic test_fill_and_drain(input bit zigzag);
    logic signed [31:0] value;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (!zigzag) value = random_value();
      else if (i % 2 == 0) value = -int'($urandom_range(1, 1000));
      else value = int'($urandom_range(1, 1000));
      send_item(FUNC_PUSH, value);
    end
    repeat (3) send_item(FUNC_PUSH, random_value());
    send_item(FUNC_PEEK, 32'sd0);
    repeat (STACK_DEPTH) send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_POP, 32'sd0);
    send_item(FUNC_PEEK, 32'sd0);
  endtask

  task automatic test_random_mix(input int item_total);
    int sent;
    int phase_len;
    int push_weight;
    int r;
    sent = 0;
    while (sent < item_total) begin
      phase_len = $urandom_range(10, 60);
      push_weight = $urandom_range(20, 80);
      back_to_back = ($urandom_range(0, 4) == 0);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(FUNC_CLEAR, random_value());
        else if (r < push_weight) send_item(FUNC_PUSH, random_value());
        else if ($urandom_range(0, 3) == 0) send_item(FUNC_PEEK, random_value());
        else send_item(FUNC_POP, random_value());
        sent++;
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain(1'b1);
    test_fill_and_drain(1'b0);
    test_random_mix(600);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
